FILE: hw/rtl/pek_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pek_pkg
// shared types, key codes and lookup functions for the pad keystroke encoder
// ----------------------------------------------------------------------------
package pek_pkg;

	localparam int KeyW   = 15;
	localparam int SlotN  = 4;
	localparam int IndexW = 4;
	localparam int ValueW = 8;
	localparam int KindW  = 2;

	typedef logic [KeyW-1:0] key_t;

	typedef enum logic [KindW-1:0] {
		KIND_BUTTON = 2'd0,
		KIND_HAT    = 2'd1,
		KIND_AXIS   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam key_t KEY_NONE   = 15'h0000;
	localparam key_t KEY_BTN_0  = 15'h5800;
	localparam key_t KEY_BTN_1  = 15'h5801;
	localparam key_t KEY_BTN_2  = 15'h5802;
	localparam key_t KEY_BTN_3  = 15'h5803;
	localparam key_t KEY_BTN_4  = 15'h5805;
	localparam key_t KEY_BTN_5  = 15'h5804;
	localparam key_t KEY_BTN_6  = 15'h5806;
	localparam key_t KEY_BTN_7  = 15'h5807;
	localparam key_t KEY_BTN_8  = 15'h5816;
	localparam key_t KEY_BTN_9  = 15'h5817;
	localparam key_t KEY_BTN_10 = 15'h5815;
	localparam key_t KEY_BTN_11 = 15'h5814;
	localparam key_t KEY_HAT_UP    = 15'h5810;
	localparam key_t KEY_HAT_RIGHT = 15'h5813;
	localparam key_t KEY_HAT_DOWN  = 15'h5811;
	localparam key_t KEY_HAT_LEFT  = 15'h5812;

	// keystrokes one event can cause, one slot per possible keystroke
	typedef struct packed {
		logic [SlotN-1:0]      pend;
		logic [SlotN-1:0]      down;
		key_t [SlotN-1:0]      key;
	} key_plan_t;

	function automatic key_t button_code(input logic [IndexW-1:0] idx);
		key_t code;
		case (idx)
			4'd0:    code = KEY_BTN_0;
			4'd1:    code = KEY_BTN_1;
			4'd2:    code = KEY_BTN_2;
			4'd3:    code = KEY_BTN_3;
			4'd4:    code = KEY_BTN_4;
			4'd5:    code = KEY_BTN_5;
			4'd6:    code = KEY_BTN_6;
			4'd7:    code = KEY_BTN_7;
			4'd8:    code = KEY_BTN_8;
			4'd9:    code = KEY_BTN_9;
			4'd10:   code = KEY_BTN_10;
			4'd11:   code = KEY_BTN_11;
			default: code = KEY_NONE;
		endcase
		return code;
	endfunction

	function automatic key_t hat_code(input logic [1:0] dir);
		key_t code;
		case (dir)
			2'd0:    code = KEY_HAT_UP;
			2'd1:    code = KEY_HAT_RIGHT;
			2'd2:    code = KEY_HAT_DOWN;
			default: code = KEY_HAT_LEFT;
		endcase
		return code;
	endfunction

endpackage

FILE: hw/rtl/pad_edge_to_keystroke_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_edge_to_keystroke_encoder
// maps gamepad button and hat edge events to pad virtual-key keystrokes
// ----------------------------------------------------------------------------
// Each accepted event is decoded combinationally into up to four keystrokes,
// which leave one per beat through a registered output. A button edge gives
// one keystroke (none for unmapped bits 12 to 15), a hat change gives one per
// changed direction bit in the order up, right, down, left, and axis or unused
// events give none and leave the input ready. The input is ready again in
// the same cycle as the last keystroke of an event is sent, so a new event
// can follow that keystroke at once; the single output channel limits how
// often hat changes with several keystrokes can be taken. Output tlast marks
// the last keystroke of an event.
module pad_edge_to_keystroke_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [3:0] event_index, [11:4] event_value, zero fill
	input  logic [1:0]  s_axis_tuser,  // [1:0] event_kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [14:0] virtual_key, zero fill
	output logic        m_axis_tuser,  // [0] key_down
	output logic        m_axis_tlast   // last_of_run
);
	import pek_pkg::*;

	key_plan_t plan;
	key_t      out_key;
	logic      accept;

	assign accept = s_axis_tvalid && s_axis_tready;

	pek_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.event_kind  (s_axis_tuser),
		.event_index (s_axis_tdata[3:0]),
		.event_value (s_axis_tdata[11:4]),
		.plan        (plan)
	);

	pek_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.plan      (plan),
		.ready     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_key   (out_key),
		.out_down  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_key};

endmodule

FILE: hw/rtl/pek_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pek_decode
// turns one pad event into a keystroke plan and tracks the last hat mask
// ----------------------------------------------------------------------------
module pek_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [pek_pkg::KindW-1:0]     event_kind,
	input  logic [pek_pkg::IndexW-1:0]    event_index,
	input  logic [pek_pkg::ValueW-1:0]    event_value,
	output pek_pkg::key_plan_t            plan
);
	import pek_pkg::*;

	logic [SlotN-1:0] last_hat_q;
	logic [SlotN-1:0] hat_now;
	logic [SlotN-1:0] hat_changed;
	key_t             btn_key;

	assign hat_now     = event_value[SlotN-1:0];
	assign hat_changed = hat_now ^ last_hat_q;
	assign btn_key     = button_code(event_index);

	always_comb begin
		plan = '0;
		case (kind_t'(event_kind))
			KIND_BUTTON: begin
				plan.pend[0] = (btn_key != KEY_NONE);
				plan.down[0] = (event_value != '0);
				plan.key[0]  = btn_key;
			end
			KIND_HAT: begin
				for (int b = 0; b < SlotN; b++) begin
					plan.pend[b] = hat_changed[b];
					plan.down[b] = hat_now[b];
					plan.key[b]  = hat_code(2'(b));
				end
			end
			default: plan = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hat_q <= '0;
		end else if (accept && kind_t'(event_kind) == KIND_HAT) begin
			last_hat_q <= hat_now;
		end
	end

endmodule

FILE: hw/rtl/pek_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pek_emit
// holds the plan of the current event and sends its keystrokes one per beat
// ----------------------------------------------------------------------------
module pek_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  pek_pkg::key_plan_t     plan,
	output logic                   ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pek_pkg::key_t          out_key,
	output logic                   out_down,
	output logic                   out_last
);
	import pek_pkg::*;

	logic [SlotN-1:0] pend_s1;
	logic [SlotN-1:0] down_s1;
	key_t [SlotN-1:0] key_s1;
	logic [SlotN-1:0] pick;
	logic [SlotN-1:0] remain;
	logic             out_free;
	logic             fire;
	key_t             pick_key;
	logic             pick_down;

	// lowest pending slot goes first: up, right, down, left
	assign pick     = pend_s1 & (~pend_s1 + 1'b1);
	assign remain   = pend_s1 & ~pick;
	assign out_free = !out_valid || out_ready;
	assign fire     = (pend_s1 != '0) && out_free;
	assign ready    = (pend_s1 == '0) || (fire && remain == '0);

	always_comb begin
		pick_key  = '0;
		pick_down = 1'b0;
		for (int b = 0; b < SlotN; b++) begin
			if (pick[b]) begin
				pick_key  = key_s1[b];
				pick_down = down_s1[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				pend_s1 <= plan.pend;
			end else if (fire) begin
				pend_s1 <= remain;
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			down_s1 <= plan.down;
			key_s1  <= plan.key;
		end
		if (fire) begin
			out_key  <= pick_key;
			out_down <= pick_down;
			out_last <= (remain == '0);
		end
	end

endmodule
